[design/record_shaker_sort_core_defines.svh]
// Assertion macros shared by the record shaker sort RTL.
`ifndef RECORD_SHAKER_SORT_CORE_DEFINES_SVH
`define RECORD_SHAKER_SORT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define RSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define RSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/rss_pkg.sv]
// Package for the record shaker sort core: sizes, payload types, states, key select.
`default_nettype none

package rss_pkg;

  localparam int unsigned MAX_RECORDS = 64;
  localparam int unsigned IDX_W       = $clog2(MAX_RECORDS);
  localparam int unsigned CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int unsigned KEY_W       = 16;

  typedef struct packed {
    logic [9:0]  record_id;
    logic [11:0] award_year;
    logic [6:0]  age;
    logic [15:0] popularity;
    logic        last_record;
  } rec_in_t;

  typedef struct packed {
    logic [9:0]  out_record_id;
    logic [11:0] out_award_year;
    logic [6:0]  out_age;
    logic [15:0] out_popularity;
    logic        out_last;
    logic        overflow;
  } rec_out_t;

  // One entry of the record store.
  typedef struct packed {
    logic [9:0]  record_id;
    logic [11:0] award_year;
    logic [6:0]  age;
    logic [15:0] popularity;
  } store_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_U_INIT,
    ST_U_LOAD,
    ST_U_RD,
    ST_U_CMP,
    ST_U_END,
    ST_D_INIT,
    ST_D_LOAD,
    ST_D_RD,
    ST_D_CMP,
    ST_D_END,
    ST_NEXT,
    ST_OUT
  } state_e;

  localparam logic KEY_AGE        = 1'b0;
  localparam logic KEY_POPULARITY = 1'b1;

  function automatic logic [KEY_W-1:0] key_of(store_t r, logic sel);
    logic [KEY_W-1:0] k;
    if (sel == KEY_POPULARITY) begin
      k = r.popularity;
    end else begin
      k = KEY_W'(r.age);
    end
    return k;
  endfunction

endpackage

`default_nettype wire

[design/record_shaker_sort_core.sv]
// Record shaker sort core: collect records, sort by a selected key, emit in order.
//
// Usage: present a record on rec_i and raise start; it transfers at a clock edge
// where start is high and busy is low. Records are appended to a 64-entry store.
// A record with last_record set (stored, or dropped if the store is full) starts
// a cocktail shaker sort by age or popularity (cfg_we_i/cfg_wdata_i, write only
// while idle), then every stored record is emitted in ascending key order, one per
// cycle, each on result_o for exactly one cycle with result_valid_o high.
// out_last marks the final record; overflow is set on every record of a run in
// which records were dropped. Equal keys keep arrival order.
// A last record starts the sort, then the output. The sort runs one shared key
// comparator over a store with one write port and one registered read port.
// Reset clears the count, the overflow flag, the key select (age) and the
// sequencer; store contents are not cleared. The receiver cannot stall:
// results are never held back.
`default_nettype none
`include "record_shaker_sort_core_defines.svh"

module record_shaker_sort_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire rss_pkg::rec_in_t rec_i,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_wdata_i,
  output logic                  result_valid_o,
  output rss_pkg::rec_out_t     result_o
);

  localparam int unsigned IW = rss_pkg::IDX_W;
  localparam int unsigned CW = rss_pkg::CNT_W;

  rss_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic            dropped_q, dropped_d;
  logic [IW-1:0]   lo_q, lo_d;
  logic [IW-1:0]   hi_q, hi_d;
  logic [IW-1:0]   i_q, i_d;
  logic            swapped_q, swapped_d;
  rss_pkg::store_t carry_q, carry_d;
  logic            key_sel_q;
  logic            res_valid_q, res_valid_d;
  logic            res_last_q, res_last_d;
  logic            res_ovf_q, res_ovf_d;

  // Record store, single write port and one registered read port.
  rss_pkg::store_t mem [rss_pkg::MAX_RECORDS];
  rss_pkg::store_t rd_q;
  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_waddr, mem_raddr;
  rss_pkg::store_t mem_wdata;

  // Shared comparator.
  rss_pkg::store_t cmp_a, cmp_b;
  logic            cmp_gt;

  rss_pkg::store_t in_rec;
  logic [CW-1:0]   cnt_m1;

  assign in_rec.record_id  = rec_i.record_id;
  assign in_rec.award_year = rec_i.award_year;
  assign in_rec.age        = rec_i.age;
  assign in_rec.popularity = rec_i.popularity;

  assign busy = (state_q != rss_pkg::ST_IDLE);

  always_comb begin
    if (state_q == rss_pkg::ST_D_CMP) begin
      cmp_a = rd_q;
      cmp_b = carry_q;
    end else begin
      cmp_a = carry_q;
      cmp_b = rd_q;
    end
    cmp_gt = rss_pkg::key_of(cmp_a, key_sel_q) > rss_pkg::key_of(cmp_b, key_sel_q);
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    i_d         = i_q;
    swapped_d   = swapped_q;
    carry_d     = carry_q;
    res_valid_d = 1'b0;
    res_last_d  = res_last_q;
    res_ovf_d   = res_ovf_q;
    mem_we      = 1'b0;
    mem_waddr   = i_q;
    mem_wdata   = carry_q;
    mem_re      = 1'b0;
    mem_raddr   = i_q;
    cnt_m1      = '0;

    case (state_q)
      rss_pkg::ST_IDLE: begin
        if (start) begin
          if (count_q < CW'(rss_pkg::MAX_RECORDS)) begin
            mem_we    = 1'b1;
            mem_waddr = count_q[IW-1:0];
            mem_wdata = in_rec;
            count_d   = count_q + CW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (rec_i.last_record) begin
            i_d       = '0;
            lo_d      = '0;
            swapped_d = 1'b0;
            cnt_m1    = count_d - CW'(1);
            hi_d      = cnt_m1[IW-1:0];
            if (count_d < CW'(2)) begin
              state_d = rss_pkg::ST_OUT;
            end else begin
              state_d = rss_pkg::ST_U_INIT;
            end
          end
        end
      end

      rss_pkg::ST_U_INIT: begin
        mem_re    = 1'b1;
        mem_raddr = lo_q;
        state_d   = rss_pkg::ST_U_LOAD;
      end

      rss_pkg::ST_U_LOAD: begin
        carry_d = rd_q;
        i_d     = lo_q;
        state_d = rss_pkg::ST_U_RD;
      end

      rss_pkg::ST_U_RD: begin
        mem_re    = 1'b1;
        mem_raddr = i_q + IW'(1);
        state_d   = rss_pkg::ST_U_CMP;
      end

      // Carry the larger record upward; write the smaller one behind it.
      rss_pkg::ST_U_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = i_q;
        if (cmp_gt) begin
          mem_wdata = rd_q;
          swapped_d = 1'b1;
        end else begin
          mem_wdata = carry_q;
          carry_d   = rd_q;
        end
        i_d = i_q + IW'(1);
        if ((i_q + IW'(1)) < hi_q) begin
          state_d = rss_pkg::ST_U_RD;
        end else begin
          state_d = rss_pkg::ST_U_END;
        end
      end

      rss_pkg::ST_U_END: begin
        mem_we    = 1'b1;
        mem_waddr = hi_q;
        mem_wdata = carry_q;
        hi_d      = hi_q - IW'(1);
        state_d   = rss_pkg::ST_D_INIT;
      end

      rss_pkg::ST_D_INIT: begin
        if (hi_q == lo_q) begin
          state_d = rss_pkg::ST_NEXT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = hi_q;
          state_d   = rss_pkg::ST_D_LOAD;
        end
      end

      rss_pkg::ST_D_LOAD: begin
        carry_d = rd_q;
        i_d     = hi_q;
        state_d = rss_pkg::ST_D_RD;
      end

      rss_pkg::ST_D_RD: begin
        mem_re    = 1'b1;
        mem_raddr = i_q - IW'(1);
        state_d   = rss_pkg::ST_D_CMP;
      end

      // Carry the smaller record downward; write the larger one behind it.
      rss_pkg::ST_D_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = i_q;
        if (cmp_gt) begin
          mem_wdata = rd_q;
          swapped_d = 1'b1;
        end else begin
          mem_wdata = carry_q;
          carry_d   = rd_q;
        end
        i_d = i_q - IW'(1);
        if ((i_q - IW'(1)) > lo_q) begin
          state_d = rss_pkg::ST_D_RD;
        end else begin
          state_d = rss_pkg::ST_D_END;
        end
      end

      rss_pkg::ST_D_END: begin
        mem_we    = 1'b1;
        mem_waddr = lo_q;
        mem_wdata = carry_q;
        state_d   = rss_pkg::ST_NEXT;
      end

      rss_pkg::ST_NEXT: begin
        lo_d = lo_q + IW'(1);
        if (swapped_q && ((lo_q + IW'(1)) < hi_q)) begin
          swapped_d = 1'b0;
          state_d   = rss_pkg::ST_U_INIT;
        end else begin
          i_d     = '0;
          state_d = rss_pkg::ST_OUT;
        end
      end

      // Stream one record per cycle; the strobe is registered with the read data.
      rss_pkg::ST_OUT: begin
        mem_re      = 1'b1;
        mem_raddr   = i_q;
        res_valid_d = 1'b1;
        res_ovf_d   = dropped_q;
        res_last_d  = ((CW'(i_q) + CW'(1)) == count_q);
        i_d         = i_q + IW'(1);
        if ((CW'(i_q) + CW'(1)) == count_q) begin
          count_d   = '0;
          dropped_d = 1'b0;
          state_d   = rss_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = rss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rss_pkg::ST_IDLE;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      swapped_q   <= 1'b0;
      key_sel_q   <= rss_pkg::KEY_AGE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      swapped_q   <= swapped_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        key_sel_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    i_q        <= i_d;
    carry_q    <= carry_d;
    res_last_q <= res_last_d;
    res_ovf_q  <= res_ovf_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign result_valid_o          = res_valid_q;
  assign result_o.out_record_id  = rd_q.record_id;
  assign result_o.out_award_year = rd_q.award_year;
  assign result_o.out_age        = rd_q.age;
  assign result_o.out_popularity = rd_q.popularity;
  assign result_o.out_last       = res_last_q;
  assign result_o.overflow       = res_ovf_q;

  `RSS_ASSERT_IMPL(a_strobe_from_out, result_valid_o, $past(state_q == rss_pkg::ST_OUT), "result strobe without output step")
  `RSS_ASSERT_NEXT(a_last_starts_run, start && !busy && rec_i.last_record, busy, "last record did not start a run")
  `RSS_ASSERT_IMPL(a_run_end_clears, result_valid_o && result_o.out_last, count_q == '0 && !dropped_q, "run end left count or flag set")
  `RSS_ASSERT_IMPL(a_up_index_bound, state_q == rss_pkg::ST_U_CMP, i_q < hi_q, "upward sweep index beyond bound")
  `RSS_ASSERT_IMPL(a_down_index_bound, state_q == rss_pkg::ST_D_CMP, i_q > lo_q, "downward sweep index beyond bound")

endmodule

`default_nettype wire
